// ===== design/clamped_linear_interpolator_assert.svh =====
// Assertion macros used by the checker file.
`ifndef CLAMPED_LINEAR_INTERPOLATOR_ASSERT_SVH
`define CLAMPED_LINEAR_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define CLI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cli assertion failed");

// Next-cycle implication, off while reset is low.
`define CLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cli assertion failed");

`endif

// ===== design/cli_pkg.sv =====
package cli_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DATA_W          = 32;
  localparam int SLOT_IN_W       = 6;
  localparam int CFG_W           = 7;
  localparam logic [CFG_W-1:0] POINTS_RESET = 7'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_FEW = 1'b1;

endpackage

// ===== design/cli_channels.sv =====
interface cli_in_if import cli_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [SLOT_IN_W-1:0]        entry_index;
  logic signed [DATA_W-1:0]    point_x;
  logic signed [DATA_W-1:0]    point_f;
  logic signed [DATA_W-1:0]    query_x;

  modport source (output valid, kind, entry_index, point_x, point_f, query_x, input ready);
  modport sink   (input valid, kind, entry_index, point_x, point_f, query_x, output ready);
endinterface

interface cli_out_if import cli_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DATA_W-1:0]    interpolated;
  logic                        status;

  modport source (output valid, interpolated, status, input ready);
  modport sink   (input valid, interpolated, status, output ready);
endinterface

interface cli_cfg_if import cli_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CFG_W-1:0]            points_in_use;

  modport source (output valid, points_in_use, input ready);
  modport sink   (input valid, points_in_use, output ready);
endinterface

// ===== design/clamped_linear_interpolator.sv =====
// Channel   | Dir | Payload                                         | Accepted when
// ----------+-----+-------------------------------------------------+----------------
// item_in   | in  | kind, entry_index, point_x, point_f, query_x    | valid & ready
// item_out  | out | interpolated, status                            | valid & ready
// cfg_ch    | in  | points_in_use                                   | valid & ready
//
// A load item is written to the table and the block stays idle. A query goes to
// the output on the error path or when clamped to an end point; otherwise it scans
// the table entries (one per cycle through the table read port) and then runs the
// 32-step shift-add multiplier and the 64-step restoring divider.
// Reset clears control state and sets points_in_use to 2; the table is not cleared.
// A finished result sits in the output register; new items are taken meanwhile, and
// a query finishing while that register is still full holds until it drains.
module clamped_linear_interpolator import cli_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cli_in_if.sink    item_in,
  cli_out_if.source item_out,
  cli_cfg_if.sink   cfg_ch
);

  localparam int IdxW  = $clog2(TABLE_DEPTH);
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int CmpW  = (CntW > CFG_W) ? CntW : CFG_W;
  localparam int SlotW = (CntW > SLOT_IN_W) ? CntW : SLOT_IN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_LAST, S_SCAN, S_PREP, S_CALC, S_POST
  } state_e;

  state_e                   state_q, state_d;
  logic [CFG_W-1:0]         points_q, points_d;
  logic [CntW-1:0]          n_q, n_d;
  logic [IdxW-1:0]          j_q, j_d;
  logic signed [DATA_W-1:0] q_q, q_d;
  logic signed [DATA_W-1:0] px_q, px_d;   // lower breakpoint of the interval
  logic signed [DATA_W-1:0] pf_q, pf_d;
  logic signed [DATA_W-1:0] cx_q, cx_d;   // upper breakpoint of the interval
  logic signed [DATA_W-1:0] cf_q, cf_d;
  logic [DATA_W-1:0]        mag_q, mag_d;
  logic [DATA_W-1:0]        t_q, t_d;
  logic [DATA_W-1:0]        w_q, w_d;
  logic                     neg_q, neg_d;
  logic                     start_q, start_d;
  logic signed [DATA_W-1:0] res_q, res_d;
  logic                     err_q, err_d;
  logic                     ov_q, ov_d;
  logic signed [DATA_W-1:0] oval_q, oval_d;
  logic                     ost_q, ost_d;

  logic                     in_acc;
  logic                     out_free;
  logic                     tbl_we;
  logic [IdxW-1:0]          rd_addr;
  logic signed [DATA_W-1:0] rd_x;
  logic signed [DATA_W-1:0] rd_f;
  logic [CmpW-1:0]          pts_ext;
  logic [CntW-1:0]          n_clip;
  logic signed [DATA_W:0]   diff_f;
  logic signed [DATA_W:0]   diff_t;
  logic signed [DATA_W:0]   diff_w;
  logic                     md_done;
  logic [DATA_W-1:0]        md_quot;

  assign item_in.ready = (state_q == S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign in_acc        = item_in.valid && item_in.ready;
  assign out_free      = !ov_q || item_out.ready;

  // drop loads aimed past the end of the table
  assign tbl_we = in_acc && (item_in.kind == KIND_LOAD) &&
                  (SlotW'(item_in.entry_index) < SlotW'(TABLE_DEPTH));

  // clip the configured count to the table depth
  assign pts_ext = CmpW'(points_q);
  assign n_clip  = (pts_ext > CmpW'(TABLE_DEPTH)) ? CntW'(TABLE_DEPTH) : CntW'(pts_ext);

  assign diff_f = {cf_q[DATA_W-1], cf_q} - {pf_q[DATA_W-1], pf_q};
  assign diff_t = {q_q[DATA_W-1], q_q} - {px_q[DATA_W-1], px_q};
  assign diff_w = {cx_q[DATA_W-1], cx_q} - {px_q[DATA_W-1], px_q};

  cli_table #(
    .Depth (TABLE_DEPTH),
    .IdxW  (IdxW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (IdxW'(item_in.entry_index)),
    .wx_i    (item_in.point_x),
    .wf_i    (item_in.point_f),
    .raddr_i (rd_addr),
    .rx_o    (rd_x),
    .rf_o    (rd_f)
  );

  cli_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .mag_i   (mag_q),
    .mult_i  (t_q),
    .div_i   (w_q),
    .done_o  (md_done),
    .quot_o  (md_quot)
  );

  always_comb begin
    state_d  = state_q;
    points_d = points_q;
    n_d      = n_q;
    j_d      = j_q;
    q_d      = q_q;
    px_d     = px_q;
    pf_d     = pf_q;
    cx_d     = cx_q;
    cf_d     = cf_q;
    mag_d    = mag_q;
    t_d      = t_q;
    w_d      = w_q;
    neg_d    = neg_q;
    start_d  = 1'b0;
    res_d    = res_q;
    err_d    = err_q;
    ov_d     = ov_q;
    oval_d   = oval_q;
    ost_d    = ost_q;
    rd_addr  = '0;

    if (cfg_ch.valid && cfg_ch.ready) begin
      points_d = cfg_ch.points_in_use;
    end
    // drain the output register
    if (ov_q && item_out.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && (item_in.kind == KIND_QUERY)) begin
          q_d = item_in.query_x;
          n_d = n_clip;
          if (n_clip < CntW'(2)) begin
            res_d   = '0;
            err_d   = STATUS_FEW;
            state_d = S_POST;
          end else begin
            rd_addr = '0;
            err_d   = STATUS_OK;
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        // clamp below the first breakpoint
        if (q_q <= rd_x) begin
          res_d   = rd_f;
          state_d = S_POST;
        end else begin
          px_d    = rd_x;
          pf_d    = rd_f;
          rd_addr = IdxW'(n_q - 1'b1);
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        // clamp above the last breakpoint
        if (q_q >= rd_x) begin
          res_d   = rd_f;
          state_d = S_POST;
        end else begin
          rd_addr = IdxW'(1);
          j_d     = IdxW'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // advance until the upper breakpoint is not below the query
        if (q_q > rd_x) begin
          px_d    = rd_x;
          pf_d    = rd_f;
          j_d     = j_q + 1'b1;
          rd_addr = j_q + 1'b1;
        end else begin
          cx_d    = rd_x;
          cf_d    = rd_f;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        neg_d = diff_f[DATA_W];
        mag_d = diff_f[DATA_W] ? DATA_W'(-diff_f) : diff_f[DATA_W-1:0];
        t_d   = diff_t[DATA_W-1:0];
        w_d   = diff_w[DATA_W-1:0];
        // an interval of zero or negative width, or a query below it, gives the lower value
        if (diff_w[DATA_W] || (diff_w == '0) || diff_t[DATA_W]) begin
          res_d   = pf_q;
          state_d = S_POST;
        end else begin
          start_d = 1'b1;
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        if (md_done) begin
          res_d   = neg_q ? (pf_q - $signed(md_quot)) : (pf_q + $signed(md_quot));
          state_d = S_POST;
        end
      end
      S_POST: begin
        // hold until the output register is free
        if (out_free) begin
          ov_d    = 1'b1;
          oval_d  = res_q;
          ost_d   = err_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      points_q <= POINTS_RESET;
      n_q      <= '0;
      j_q      <= '0;
      q_q      <= '0;
      px_q     <= '0;
      pf_q     <= '0;
      cx_q     <= '0;
      cf_q     <= '0;
      mag_q    <= '0;
      t_q      <= '0;
      w_q      <= '0;
      neg_q    <= 1'b0;
      start_q  <= 1'b0;
      res_q    <= '0;
      err_q    <= STATUS_OK;
      ov_q     <= 1'b0;
      oval_q   <= '0;
      ost_q    <= STATUS_OK;
    end else begin
      state_q  <= state_d;
      points_q <= points_d;
      n_q      <= n_d;
      j_q      <= j_d;
      q_q      <= q_d;
      px_q     <= px_d;
      pf_q     <= pf_d;
      cx_q     <= cx_d;
      cf_q     <= cf_d;
      mag_q    <= mag_d;
      t_q      <= t_d;
      w_q      <= w_d;
      neg_q    <= neg_d;
      start_q  <= start_d;
      res_q    <= res_d;
      err_q    <= err_d;
      ov_q     <= ov_d;
      oval_q   <= oval_d;
      ost_q    <= ost_d;
    end
  end

  assign item_out.valid        = ov_q;
  assign item_out.interpolated = oval_q;
  assign item_out.status       = ost_q;

endmodule

// ===== design/cli_table.sv =====
module cli_table import cli_pkg::*; #(
  parameter int Depth = DEF_TABLE_DEPTH,
  parameter int IdxW  = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [IdxW-1:0]          waddr_i,
  input  logic signed [DATA_W-1:0] wx_i,
  input  logic signed [DATA_W-1:0] wf_i,
  input  logic [IdxW-1:0]          raddr_i,
  output logic signed [DATA_W-1:0] rx_o,
  output logic signed [DATA_W-1:0] rf_o
);

  logic signed [DATA_W-1:0] x_mem [Depth];
  logic signed [DATA_W-1:0] f_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      x_mem[waddr_i] <= wx_i;
      f_mem[waddr_i] <= wf_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_o <= x_mem[raddr_i];
    rf_o <= f_mem[raddr_i];
  end

endmodule

// ===== design/cli_muldiv.sv =====
module cli_muldiv import cli_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] mag_i,
  input  logic [DATA_W-1:0] mult_i,
  input  logic [DATA_W-1:0] div_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quot_o
);

  localparam int AccW = 2 * DATA_W;
  localparam int CntW = $clog2(AccW);

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_e;

  md_state_e         state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [DATA_W-1:0] mc_q, mc_d;
  logic [DATA_W-1:0] w_q, w_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic              done_q, done_d;

  logic [DATA_W:0]   add_sum;
  logic [DATA_W:0]   rem_shift;
  logic [DATA_W:0]   rem_diff;
  logic              q_bit;

  // shift-add step: add multiplicand to upper half when the low bit is set
  assign add_sum   = {1'b0, acc_q[AccW-1:DATA_W]} + (acc_q[0] ? {1'b0, mc_q} : '0);
  // restoring division step: one quotient bit per cycle
  assign rem_shift = {rem_q, acc_q[AccW-1]};
  assign rem_diff  = rem_shift - {1'b0, w_q};
  assign q_bit     = (rem_shift >= {1'b0, w_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    mc_d    = mc_q;
    w_d     = w_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          acc_d   = {{DATA_W{1'b0}}, mult_i};
          mc_d    = mag_i;
          w_d     = div_i;
          rem_d   = '0;
          cnt_d   = CntW'(DATA_W - 1);
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        acc_d = {add_sum, acc_q[DATA_W-1:1]};
        if (cnt_q == '0) begin
          cnt_d   = CntW'(AccW - 1);
          state_d = MD_DIV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      MD_DIV: begin
        rem_d = q_bit ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
        acc_d = {acc_q[AccW-2:0], q_bit};
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = MD_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      acc_q   <= '0;
      mc_q    <= '0;
      w_q     <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      acc_q   <= acc_d;
      mc_q    <= mc_d;
      w_q     <= w_d;
      rem_q   <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q[DATA_W-1:0];

endmodule

// ===== design/cli_checker.sv =====
`include "clamped_linear_interpolator_assert.svh"

module cli_checker import cli_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_kind,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_interpolated,
  input logic              out_status
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // a stalled result keeps its value
  `CLI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid && $stable(out_interpolated) && $stable(out_status))
  // the error status always carries a zero value
  `CLI_ASSERT_NOW(a_err_zero, clk_i, rst_ni, out_valid && (out_status == STATUS_FEW), out_interpolated == '0)
  // a query occupies the block
  `CLI_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_acc && (in_kind == KIND_QUERY), !in_ready)
  // no result appears straight off an accepted item
  `CLI_ASSERT_NEXT(a_no_instant, clk_i, rst_ni, in_acc, !$rose(out_valid))

endmodule

bind clamped_linear_interpolator cli_checker u_cli_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid         (item_in.valid),
  .in_ready         (item_in.ready),
  .in_kind          (item_in.kind),
  .out_valid        (item_out.valid),
  .out_ready        (item_out.ready),
  .out_interpolated (item_out.interpolated),
  .out_status       (item_out.status)
);
